### rtl/movement_command_delta_encoder_defines.svh
// ----------------------------------------------------------------------------
// Movement command delta encoder assertion macros
// Shared macros for the concurrent checks on the encoder ports.
// ----------------------------------------------------------------------------
`ifndef MOVEMENT_COMMAND_DELTA_ENCODER_DEFINES_SVH
`define MOVEMENT_COMMAND_DELTA_ENCODER_DEFINES_SVH

// Clocked on clk_i and disabled while rst_ni is low.
`define MCDE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked on clk_i and checked during reset as well.
`define MCDE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/mcde_pkg.sv
// ----------------------------------------------------------------------------
// Movement command delta encoder package
// Types and constants shared by the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package mcde_pkg;

  localparam int unsigned CmdW     = 120;
  localparam int unsigned NumSlots = 16;
  localparam int unsigned SlotW    = 8;

  // Bit positions in the mask byte.
  localparam int unsigned MaskPitch   = 0;
  localparam int unsigned MaskRoll    = 1;
  localparam int unsigned MaskForward = 2;
  localparam int unsigned MaskSide    = 3;
  localparam int unsigned MaskUp      = 4;
  localparam int unsigned MaskButtons = 5;
  localparam int unsigned MaskImpulse = 6;
  localparam int unsigned MaskYaw     = 7;

  // Duration always occupies the final byte slot.
  localparam int unsigned SlotDuration = NumSlots - 1;

  typedef logic [NumSlots-1:0] slot_vec_t;

  // One classified command: the mask byte followed by the raw command bytes,
  // and one flag per byte telling whether it goes on the wire.
  typedef struct packed {
    slot_vec_t                    slot_vld;
    logic [NumSlots*SlotW-1:0]    bytes;
  } entry_t;

endpackage

### rtl/mcde_front.sv
// ----------------------------------------------------------------------------
// Movement command delta encoder front end
// Accepts commands, compares them with the reference and builds queue entries.
// ----------------------------------------------------------------------------
module mcde_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   delta_mode_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [mcde_pkg::CmdW-1:0] s_axis_tdata,
  input  logic                   full_i,
  output logic                   push_o,
  output mcde_pkg::entry_t       entry_o
);

  logic [111:0] prev_q, prev_d;
  logic [111:0] ref_cmd;
  logic [7:0]   mask;
  logic         d_pitch, d_yaw, d_roll, d_fwd, d_side, d_up, d_btn, d_imp;

  assign s_axis_tready = !full_i;
  assign push_o        = s_axis_tvalid && !full_i;

  assign ref_cmd = delta_mode_i ? prev_q : '0;

  assign d_pitch = s_axis_tdata[15:0]    != ref_cmd[15:0];
  assign d_yaw   = s_axis_tdata[31:16]   != ref_cmd[31:16];
  assign d_roll  = s_axis_tdata[47:32]   != ref_cmd[47:32];
  assign d_fwd   = s_axis_tdata[63:48]   != ref_cmd[63:48];
  assign d_side  = s_axis_tdata[79:64]   != ref_cmd[79:64];
  assign d_up    = s_axis_tdata[95:80]   != ref_cmd[95:80];
  assign d_btn   = s_axis_tdata[103:96]  != ref_cmd[103:96];
  assign d_imp   = s_axis_tdata[111:104] != ref_cmd[111:104];

  always_comb begin
    mask                        = '0;
    mask[mcde_pkg::MaskPitch]   = d_pitch;
    mask[mcde_pkg::MaskRoll]    = d_roll;
    mask[mcde_pkg::MaskForward] = d_fwd;
    mask[mcde_pkg::MaskSide]    = d_side;
    mask[mcde_pkg::MaskUp]      = d_up;
    mask[mcde_pkg::MaskButtons] = d_btn;
    mask[mcde_pkg::MaskImpulse] = d_imp;
    mask[mcde_pkg::MaskYaw]     = d_yaw;
  end

  assign entry_o.bytes    = {s_axis_tdata, mask};
  assign entry_o.slot_vld = {1'b1, d_imp, d_btn, d_up, d_up, d_side, d_side,
                             d_fwd, d_fwd, d_roll, d_roll, d_yaw, d_yaw,
                             d_pitch, d_pitch, 1'b1};

  assign prev_d = push_o ? s_axis_tdata[111:0] : prev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else begin
      prev_q <= prev_d;
    end
  end

endmodule

### rtl/mcde_fifo.sv
// ----------------------------------------------------------------------------
// Movement command delta encoder queue
// Short first-in first-out queue of classified commands.
// ----------------------------------------------------------------------------
module mcde_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  mcde_pkg::entry_t entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output mcde_pkg::entry_t entry_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  mcde_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = cnt_q == CntW'(Depth);
  assign valid_o = cnt_q != '0;
  assign entry_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

### rtl/mcde_back.sv
// ----------------------------------------------------------------------------
// Movement command delta encoder back end
// Walks each entry's flagged byte slots; one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
module mcde_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  mcde_pkg::entry_t entry_i,
  output logic             pop_o,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [7:0]       m_axis_tdata,
  output logic             m_axis_tlast
);

  localparam int unsigned NumSlots = mcde_pkg::NumSlots;
  localparam int unsigned SlotW    = mcde_pkg::SlotW;

  mcde_pkg::slot_vec_t         rem_q, rem_d, rem_after, pick;
  logic [NumSlots*SlotW-1:0]   cur_q, cur_d;
  logic [SlotW-1:0]            sel_byte;
  logic                        adv;
  logic                        vld_q, vld_d, last_q, last_d;
  logic [SlotW-1:0]            data_q, data_d;

  assign pick = rem_q & (~rem_q + 1'b1);

  always_comb begin
    sel_byte = '0;
    for (int i = 0; i < NumSlots; i++) begin
      sel_byte = sel_byte | (cur_q[i*SlotW +: SlotW] & {SlotW{pick[i]}});
    end
  end

  assign adv       = (rem_q != '0) && (!vld_q || m_axis_tready);
  assign rem_after = adv ? (rem_q & ~pick) : rem_q;
  assign pop_o     = valid_i && (rem_after == '0);
  assign rem_d     = pop_o ? entry_i.slot_vld : rem_after;
  assign cur_d     = pop_o ? entry_i.bytes : cur_q;

  always_comb begin
    vld_d  = vld_q;
    data_d = data_q;
    last_d = last_q;
    if (adv) begin
      vld_d  = 1'b1;
      data_d = sel_byte;
      last_d = pick[mcde_pkg::SlotDuration];
    end else if (m_axis_tready) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      vld_q <= 1'b0;
    end else begin
      rem_q <= rem_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    data_q <= data_d;
    last_q <= last_d;
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tlast  = last_q;

endmodule

### rtl/movement_command_delta_encoder.sv
// An accepted command passes the queue and slot register to the output register.
// Throughput: one output byte per cycle while the output is ready; a command
// emits 2 to 16 bytes as the back end's byte sequencer walks its flagged slots.
// A new command is accepted every cycle while the command queue has room.
// Reset clears the previous command, the mode register and all queues.
// ----------------------------------------------------------------------------
// Movement command delta encoder
// Encodes movement commands as a change mask, the changed fields and duration.
// ----------------------------------------------------------------------------
module movement_command_delta_encoder #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // APB configuration port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  // Command stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // angle_pitch, angle_yaw, angle_roll, forward_move, side_move, up_move,
  // button_bits, impulse_code, duration_ms
  input  logic [119:0] s_axis_tdata,
  // Byte stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_byte
  output logic [7:0]   m_axis_tdata,
  output logic         m_axis_tlast
);

  logic             delta_mode_q, delta_mode_d;
  logic             push, full, q_valid, pop;
  mcde_pkg::entry_t push_entry, head_entry;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {31'b0, delta_mode_q} : '0;

  assign delta_mode_d = (psel && penable && pwrite && pready && (paddr[2] == 1'b0))
                        ? pwdata[0] : delta_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delta_mode_q <= 1'b0;
    end else begin
      delta_mode_q <= delta_mode_d;
    end
  end

  mcde_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .delta_mode_i  (delta_mode_q),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .full_i        (full),
    .push_o        (push),
    .entry_o       (push_entry)
  );

  mcde_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .entry_o (head_entry)
  );

  mcde_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (q_valid),
    .entry_i       (head_entry),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

### rtl/mcde_checker.sv
// ----------------------------------------------------------------------------
// Movement command delta encoder checker
// Port-level checks on the encoder, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "movement_command_delta_encoder_defines.svh"

module mcde_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         psel,
  input logic         penable,
  input logic         pwrite,
  input logic [2:0]   paddr,
  input logic [31:0]  pwdata,
  input logic [31:0]  prdata,
  input logic         pready,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [7:0]   m_axis_tdata,
  input logic         m_axis_tlast
);

  // A stalled output byte keeps its value and its end marker.
  `MCDE_ASSERT(a_out_hold, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)), "output changed while stalled")

  // The input only backs up while the output side has a byte pending.
  `MCDE_ASSERT(a_backpressure, !s_axis_tready |-> m_axis_tvalid, "input stalled with no output pending")

  // A write to the mode register reads back on the next cycle at its address.
  `MCDE_ASSERT(a_mode_readback, (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) |=> (paddr[2] || (prdata[0] == $past(pwdata[0]))), "mode register readback mismatch")

  // The output stays idle from the cycle after reset is seen.
  `MCDE_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !m_axis_tvalid, "output valid during reset")

endmodule

bind movement_command_delta_encoder mcde_checker u_mcde_checker (.*);

### test/tb.sv
// ----------------------------------------------------------------------------
// Movement command delta encoder testbench
// Drives commands on the slave stream and APB mode writes, predicts the byte
// stream of each command, and checks every byte with its last flag in order.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] ModeAddr   = 3'd0;
  localparam logic [2:0] UnusedAddr = 3'd4;

  // Member order packs angle_pitch into the lowest bits of tdata.
  typedef struct packed {
    logic [7:0]         duration;
    logic [7:0]         impulse;
    logic [7:0]         buttons;
    logic signed [15:0] up;
    logic signed [15:0] side;
    logic signed [15:0] fwd;
    logic [15:0]        roll;
    logic [15:0]        yaw;
    logic [15:0]        pitch;
  } move_cmd_t;

  typedef struct packed {
    logic       last;
    logic [7:0] value;
  } wire_byte_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [2:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [119:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [7:0]   m_axis_tdata;
  logic         m_axis_tlast;

  wire_byte_t pending_bytes[$];
  move_cmd_t  last_cmd = '0;
  logic       mode_shadow = 1'b0;
  int         n_errors = 0;
  int         hold_req = 0;
  int         rx_run = 1;
  int         rx_stall = 0;
  int         tx_burst = 1;
  int         tx_gap = 0;
  int         burst_left = 0;

  movement_command_delta_encoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic void note_mismatch(input string what, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
    n_errors++;
    if (n_errors <= 10) begin
      $display("%0t: mismatch on %s: expected %h, actual %h", $realtime, what, exp_v, act_v);
    end
  endfunction

  function automatic void push_byte(input logic [7:0] value, input logic last);
    wire_byte_t b;
    b.value = value;
    b.last  = last;
    pending_bytes.push_back(b);
  endfunction

  function automatic void push_word(input logic [15:0] value);
    push_byte(value[7:0], 1'b0);
    push_byte(value[15:8], 1'b0);
  endfunction

  // Builds the byte stream of one command and then stores it as the
  // reference for the next one, whatever the mode.
  function automatic void encode_command(input move_cmd_t c);
    move_cmd_t  r;
    logic [7:0] mask;
    r = mode_shadow ? last_cmd : '0;
    mask = '0;
    mask[mcde_pkg::MaskPitch]   = c.pitch != r.pitch;
    mask[mcde_pkg::MaskYaw]     = c.yaw != r.yaw;
    mask[mcde_pkg::MaskRoll]    = c.roll != r.roll;
    mask[mcde_pkg::MaskForward] = c.fwd != r.fwd;
    mask[mcde_pkg::MaskSide]    = c.side != r.side;
    mask[mcde_pkg::MaskUp]      = c.up != r.up;
    mask[mcde_pkg::MaskButtons] = c.buttons != r.buttons;
    mask[mcde_pkg::MaskImpulse] = c.impulse != r.impulse;
    push_byte(mask, 1'b0);
    if (mask[mcde_pkg::MaskPitch]) push_word(c.pitch);
    if (mask[mcde_pkg::MaskYaw]) push_word(c.yaw);
    if (mask[mcde_pkg::MaskRoll]) push_word(c.roll);
    if (mask[mcde_pkg::MaskForward]) push_word(c.fwd);
    if (mask[mcde_pkg::MaskSide]) push_word(c.side);
    if (mask[mcde_pkg::MaskUp]) push_word(c.up);
    if (mask[mcde_pkg::MaskButtons]) push_byte(c.buttons, 1'b0);
    if (mask[mcde_pkg::MaskImpulse]) push_byte(c.impulse, 1'b0);
    push_byte(c.duration, 1'b1);
    last_cmd = c;
  endfunction

  function automatic logic [15:0] rand16();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      3: return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] rand8();
    case ($urandom_range(5))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic move_cmd_t random_cmd(input logic from_zero, input int change_pct);
    move_cmd_t c;
    c = from_zero ? '0 : last_cmd;
    if ($urandom_range(99) < change_pct) c.pitch = rand16();
    if ($urandom_range(99) < change_pct) c.yaw = rand16();
    if ($urandom_range(99) < change_pct) c.roll = rand16();
    if ($urandom_range(99) < change_pct) c.fwd = rand16();
    if ($urandom_range(99) < change_pct) c.side = rand16();
    if ($urandom_range(99) < change_pct) c.up = rand16();
    if ($urandom_range(99) < change_pct) c.buttons = rand8();
    if ($urandom_range(99) < change_pct) c.impulse = rand8();
    c.duration = rand8();
    return c;
  endfunction

  task automatic send_cmd(input move_cmd_t c);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, tx_burst);
      gap = (tx_gap > 0) ? $urandom_range(0, tx_gap) : 0;
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tdata  <= c;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    encode_command(c);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {31'($urandom), value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == ModeAddr) mode_shadow = value;
    @(posedge clk_i);
  endtask

  task automatic apb_read_check();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ModeAddr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== {31'b0, mode_shadow}) begin
      note_mismatch("mode readback", {31'b0, mode_shadow}, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin : rx_pacing
    int n;
    forever begin
      if (hold_req > 0) begin
        n = hold_req;
        hold_req = 0;
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end else if (rx_stall == 0) begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, rx_run)) @(posedge clk_i);
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, rx_stall)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    wire_byte_t exp_b;
    wire_byte_t act_b;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      act_b.value = m_axis_tdata;
      act_b.last  = m_axis_tlast;
      if (pending_bytes.size() == 0) begin
        note_mismatch("unexpected byte", 'x, 32'(act_b));
      end else begin
        exp_b = pending_bytes.pop_front();
        if (act_b.value !== exp_b.value) note_mismatch("out_byte", exp_b.value, act_b.value);
        if (act_b.last !== exp_b.last) note_mismatch("last_byte", exp_b.last, act_b.last);
      end
    end
  end

  // Mode 1 before any command must compare against zeros.
  task automatic test_mode_from_reset();
    move_cmd_t c;
    apb_read_check();
    apb_write(ModeAddr, 1'b1);
    apb_read_check();
    c = '{duration: 8'h00, impulse: 8'h5A, buttons: 8'h00, up: 16'sh0000,
          side: 16'sh1234, fwd: 16'sh0000, roll: 16'hBEEF, yaw: 16'h0000, pitch: 16'h0001};
    send_cmd(c);
    wait_idle();
    apb_write(ModeAddr, 1'b0);
    apb_read_check();
  endtask

  task automatic test_field_extremes();
    move_cmd_t c;
    send_cmd('0);
    c = '1;
    send_cmd(c);
    c = '{duration: 8'hFF, impulse: 8'h01, buttons: 8'h80, up: 16'sh8000,
          side: 16'sh8000, fwd: 16'sh8000, roll: 16'h8000, yaw: 16'h0001, pitch: 16'hFFFF};
    send_cmd(c);
    c = '{duration: 8'h00, impulse: 8'hFE, buttons: 8'h7F, up: 16'sh7FFF,
          side: 16'sh7FFF, fwd: 16'sh7FFF, roll: 16'h7FFF, yaw: 16'hFFFE, pitch: 16'h0000};
    send_cmd(c);
    for (int i = 0; i < 8; i++) begin
      c = '0;
      c.duration = 8'(i * 31);
      case (i)
        0: c.pitch = 16'hA55A;
        1: c.yaw = 16'h5AA5;
        2: c.roll = 16'hFFFF;
        3: c.fwd = -16'sd1;
        4: c.side = 16'sh8000;
        5: c.up = 16'sh7FFF;
        6: c.buttons = 8'hFF;
        default: c.impulse = 8'h81;
      endcase
      send_cmd(c);
    end
    wait_idle();
  endtask

  task automatic test_unused_register();
    apb_write(UnusedAddr, 1'b1);
    apb_read_check();
    send_cmd(random_cmd(1'b0, 100));
    wait_idle();
  endtask

  task automatic test_previous_compare();
    move_cmd_t c;
    apb_write(ModeAddr, 1'b1);
    apb_read_check();
    c = random_cmd(1'b0, 100);
    send_cmd(c);
    c.duration = 8'hFF;
    send_cmd(c);
    c.yaw = c.yaw + 16'd1;
    send_cmd(c);
    c.buttons = ~c.buttons;
    c.up = -c.up;
    send_cmd(c);
    send_cmd('0);
    send_cmd('1);
    wait_idle();
  endtask

  task automatic test_backpressure();
    tx_burst = 1;
    tx_gap = 0;
    rx_stall = 0;
    hold_req = 300;
    for (int i = 0; i < 20; i++) send_cmd(random_cmd(1'b0, 60));
    wait_idle();
  endtask

  task automatic test_random_traffic();
    move_cmd_t c;
    int sel;
    for (int phase = 0; phase < 6; phase++) begin
      wait_idle();
      apb_write(ModeAddr, (phase % 2 == 0) ? 1'b1 : 1'($urandom));
      tx_burst = $urandom_range(1, 12);
      tx_gap   = (phase == 2) ? 0 : $urandom_range(0, 6);
      rx_run   = $urandom_range(1, 10);
      rx_stall = (phase == 3) ? 0 : $urandom_range(0, 6);
      for (int i = 0; i < 54; i++) begin
        sel = $urandom_range(99);
        if (mode_shadow) begin
          if (sel < 85) c = random_cmd(1'b0, (sel < 10) ? 0 : 25);
          else c = random_cmd(sel < 92, 100);
        end else begin
          c = random_cmd(sel < 70, (sel < 35) ? 30 : 100);
        end
        send_cmd(c);
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_mode_from_reset();
    test_field_extremes();
    test_unused_register();
    test_previous_compare();
    test_backpressure();
    test_random_traffic();
    rx_stall = 0;
    wait_idle();
    repeat (20) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
